>>> src/plrud_pkg.sv
// Package for the partitioned LRU directory: field widths, defaults and the
// controller command type. Depends on nothing; every other file imports it.
package plrud_pkg;

   localparam int TENANT_COUNT_DEFAULT     = 4;
   localparam int SLOTS_PER_TENANT_DEFAULT = 16;
   localparam int PAGE_WIDTH_DEFAULT       = 16;

   localparam int TENANT_FIELD_WIDTH = 2;
   localparam int PAGE_FIELD_WIDTH   = 16;
   localparam int SLOT_FIELD_WIDTH   = 5;
   localparam int FAULT_WIDTH        = 32;

   localparam int QUOTA_REGS      = 4;
   localparam int QUOTA_WIDTH     = 5;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [QUOTA_WIDTH-1:0] QUOTA_RESET = 5'd16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUOTA_TENANT0 = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUOTA_TENANT1 = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUOTA_TENANT2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUOTA_TENANT3 = 2'd3;

   typedef struct packed {
      logic capture;
      logic update;
   } plrud_cmd_type;

endpackage

>>> src/plrud_ctrl.sv
// Controller of the partitioned LRU directory: a two-state sequencer that
// issues capture and update commands. Depends on plrud_pkg.
module plrud_ctrl
   import plrud_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output plrud_cmd_type cmd
);

   localparam logic STATE_IDLE   = 1'b0;
   localparam logic STATE_UPDATE = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      cmd.capture = (state_ff == STATE_IDLE) && start;
      cmd.update  = (state_ff == STATE_UPDATE);
      busy        = (state_ff != STATE_IDLE);
      unique case (state_ff)
         STATE_IDLE:   state_in = start ? STATE_UPDATE : STATE_IDLE;
         STATE_UPDATE: state_in = STATE_IDLE;
         default:      state_in = STATE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_then_update: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.update && busy)
      else $error("Accepted request was not followed by an update cycle.");

endmodule

>>> src/plrud_datapath.sv
// Datapath of the partitioned LRU directory: quota registers, tag and rank row
// memories, fill levels, miss counters and the result register. Depends on plrud_pkg.
module plrud_datapath
   import plrud_pkg::*;
#(
   parameter int TENANT_COUNT     = TENANT_COUNT_DEFAULT,
   parameter int SLOTS_PER_TENANT = SLOTS_PER_TENANT_DEFAULT,
   parameter int PAGE_WIDTH       = PAGE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  plrud_cmd_type                 cmd,
   input  logic [TENANT_FIELD_WIDTH-1:0] req_tenant,
   input  logic [PAGE_FIELD_WIDTH-1:0]   req_page_number,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [QUOTA_WIDTH-1:0]        csr_write_data,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [SLOT_FIELD_WIDTH-1:0]   rsp_slot_number,
   output logic                          rsp_evicted,
   output logic [PAGE_FIELD_WIDTH-1:0]   rsp_victim_page,
   output logic                          rsp_bypassed,
   output logic [FAULT_WIDTH-1:0]        rsp_fault_count
);

   localparam int TIDX_W = (TENANT_COUNT > 1) ? $clog2(TENANT_COUNT) : 1;
   localparam int SIDX_W = (SLOTS_PER_TENANT > 1) ? $clog2(SLOTS_PER_TENANT) : 1;
   localparam int RANK_W = SIDX_W;
   localparam int FILL_W = $clog2(SLOTS_PER_TENANT + 1);

   logic [QUOTA_WIDTH-1:0] quota_ff [QUOTA_REGS];

   logic [SLOTS_PER_TENANT-1:0][PAGE_WIDTH-1:0] tag_mem  [TENANT_COUNT];
   logic [SLOTS_PER_TENANT-1:0][RANK_W-1:0]     rank_mem [TENANT_COUNT];
   logic [SLOTS_PER_TENANT-1:0][PAGE_WIDTH-1:0] tag_row_ff;
   logic [SLOTS_PER_TENANT-1:0][RANK_W-1:0]     rank_row_ff;
   logic [SLOTS_PER_TENANT-1:0][PAGE_WIDTH-1:0] tag_row_in;
   logic [SLOTS_PER_TENANT-1:0][RANK_W-1:0]     rank_row_in;

   logic [FILL_W-1:0]      fill_ff [TENANT_COUNT];
   logic [FAULT_WIDTH-1:0] miss_ff [TENANT_COUNT];
   logic [FILL_W-1:0]      fill_in;
   logic [FAULT_WIDTH-1:0] miss_in;

   logic                          in_range_ff;
   logic [TIDX_W-1:0]             tidx_ff;
   logic [TENANT_FIELD_WIDTH-1:0] tenant_ff;
   logic [PAGE_WIDTH-1:0]         page_ff;

   logic                  req_in_range;
   logic [TIDX_W-1:0]     req_tidx;
   logic [FILL_W-1:0]     fill_cur;
   logic [FILL_W-1:0]     quota_cur;
   logic [FAULT_WIDTH-1:0] miss_cur;
   logic                  quota_zero;
   logic                  full;
   logic                  hit_found;
   logic [SIDX_W-1:0]     hit_slot;
   logic [SIDX_W-1:0]     lru_slot;
   logic                  hit;
   logic                  evict;
   logic                  fill_new;
   logic [SIDX_W-1:0]     sel_slot;
   logic [RANK_W-1:0]     age_limit;
   logic                  age_all;
   logic                  row_write;

   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic [SLOT_FIELD_WIDTH-1:0] rsp_slot_number_ff;
   logic                        rsp_evicted_ff;
   logic [PAGE_FIELD_WIDTH-1:0] rsp_victim_page_ff;
   logic                        rsp_bypassed_ff;
   logic [FAULT_WIDTH-1:0]      rsp_fault_count_ff;

   assign req_in_range = (32'(req_tenant) < TENANT_COUNT) && (32'(req_tenant) < QUOTA_REGS);
   assign req_tidx     = req_in_range ? TIDX_W'(32'(req_tenant)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         quota_ff[0] <= QUOTA_RESET;
         quota_ff[1] <= QUOTA_RESET;
         quota_ff[2] <= QUOTA_RESET;
         quota_ff[3] <= QUOTA_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_QUOTA_TENANT0: quota_ff[0] <= csr_write_data;
            REG_QUOTA_TENANT1: quota_ff[1] <= csr_write_data;
            REG_QUOTA_TENANT2: quota_ff[2] <= csr_write_data;
            REG_QUOTA_TENANT3: quota_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_range_ff <= req_in_range;
         tidx_ff     <= req_tidx;
         tenant_ff   <= req_tenant;
         page_ff     <= PAGE_WIDTH'(32'(req_page_number));
         tag_row_ff  <= tag_mem[req_tidx];
         rank_row_ff <= rank_mem[req_tidx];
      end
      if (row_write) begin
         tag_mem[tidx_ff]  <= tag_row_in;
         rank_mem[tidx_ff] <= rank_row_in;
      end
   end

   always_comb begin
      fill_cur   = fill_ff[tidx_ff];
      miss_cur   = miss_ff[tidx_ff];
      quota_cur  = (32'(quota_ff[tenant_ff]) > SLOTS_PER_TENANT) ?
                   FILL_W'(SLOTS_PER_TENANT) : FILL_W'(32'(quota_ff[tenant_ff]));
      quota_zero = (quota_cur == '0);
      full       = (fill_cur >= quota_cur);

      hit_found = 1'b0;
      hit_slot  = '0;
      lru_slot  = '0;
      for (int i = SLOTS_PER_TENANT - 1; i >= 0; i--) begin
         if ((i < 32'(fill_cur)) && (tag_row_ff[i] == page_ff)) begin
            hit_found = 1'b1;
            hit_slot  = SIDX_W'(i);
         end
         if ((i < 32'(fill_cur)) && (32'(rank_row_ff[i]) == 32'(fill_cur) - 32'd1)) begin
            lru_slot = SIDX_W'(i);
         end
      end

      hit      = hit_found && !quota_zero;
      evict    = !hit_found && !quota_zero && full;
      fill_new = !hit_found && !quota_zero && !full;
      age_all  = fill_new;

      priority if (hit) begin
         sel_slot  = hit_slot;
         age_limit = rank_row_ff[hit_slot];
      end else if (evict) begin
         sel_slot  = lru_slot;
         age_limit = rank_row_ff[lru_slot];
      end else begin
         sel_slot  = SIDX_W'(32'(fill_cur));
         age_limit = '0;
      end

      tag_row_in  = tag_row_ff;
      rank_row_in = rank_row_ff;
      for (int i = 0; i < SLOTS_PER_TENANT; i++) begin
         if ((i < 32'(fill_cur)) && (age_all || (rank_row_ff[i] < age_limit))) begin
            rank_row_in[i] = rank_row_ff[i] + RANK_W'(1);
         end
      end
      rank_row_in[sel_slot] = '0;
      if (!hit) begin
         tag_row_in[sel_slot] = page_ff;
      end

      row_write = cmd.update && in_range_ff && !quota_zero;
      fill_in   = fill_new ? fill_cur + FILL_W'(1) : fill_cur;
      miss_in   = (!hit && (miss_cur != '1)) ? miss_cur + FAULT_WIDTH'(1) : miss_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TENANT_COUNT; t++) begin
            fill_ff[t] <= '0;
            miss_ff[t] <= '0;
         end
      end else if (cmd.update && in_range_ff) begin
         fill_ff[tidx_ff] <= fill_in;
         miss_ff[tidx_ff] <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         if (in_range_ff && !quota_zero) begin
            rsp_hit_ff         <= hit;
            rsp_slot_number_ff <= SLOT_FIELD_WIDTH'(32'(sel_slot) + 32'd1);
            rsp_evicted_ff     <= evict;
            rsp_victim_page_ff <= evict ? PAGE_FIELD_WIDTH'(32'(tag_row_ff[lru_slot])) : '0;
            rsp_bypassed_ff    <= 1'b0;
         end else begin
            rsp_hit_ff         <= 1'b0;
            rsp_slot_number_ff <= '0;
            rsp_evicted_ff     <= 1'b0;
            rsp_victim_page_ff <= '0;
            rsp_bypassed_ff    <= 1'b1;
         end
         rsp_fault_count_ff <= in_range_ff ? miss_in : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot_number = rsp_slot_number_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_victim_page = rsp_victim_page_ff;
   assign rsp_bypassed    = rsp_bypassed_ff;
   assign rsp_fault_count = rsp_fault_count_ff;

   a_update_gives_result: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid_ff)
      else $error("Update cycle did not produce a result.");

   a_hit_excludes_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> !rsp_evicted_ff && !rsp_bypassed_ff)
      else $error("A hit was also reported as an eviction or a bypass.");

   a_bypass_has_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bypassed_ff |-> (rsp_slot_number_ff == '0) && !rsp_evicted_ff)
      else $error("A bypassed request reported a slot or an eviction.");

endmodule

>>> src/partitioned_lru_directory.sv
// Top level of the partitioned LRU directory: joins the controller and the
// datapath. Depends on plrud_pkg, plrud_ctrl and plrud_datapath.
//
// A request (req_tenant, req_page_number) is taken at a rising edge where start
// is high and busy is low. The tenant's tag and rank row is read from the row
// memory at that edge and updated in the following cycle. The result is
// registered at the end of that update cycle and is marked on the rsp_ ports by
// rsp_valid, which is high for exactly one cycle. busy is high for the one update
// cycle after each request, and no new request is taken while busy is high; the
// pace is set by the single read-modify-write of the tenant's row, and the result
// register lets the next request enter while the previous result is on the ports.
// Quota registers are to be written through csr_write_enable, csr_index and
// csr_write_data only while the block is idle; the block does not enforce this.
// Reset is synchronous and active high: it sets every quota to 16 and clears
// the fill levels, the miss counters and the controller; the row memories need
// no clearing since only filled slots are read. The receiver cannot stall:
// each result must be taken in its one cycle.
module partitioned_lru_directory
   import plrud_pkg::*;
#(
   parameter int TENANT_COUNT     = TENANT_COUNT_DEFAULT,
   parameter int SLOTS_PER_TENANT = SLOTS_PER_TENANT_DEFAULT,
   parameter int PAGE_WIDTH       = PAGE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [TENANT_FIELD_WIDTH-1:0] req_tenant,
   input  logic [PAGE_FIELD_WIDTH-1:0]   req_page_number,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [SLOT_FIELD_WIDTH-1:0]   rsp_slot_number,
   output logic                          rsp_evicted,
   output logic [PAGE_FIELD_WIDTH-1:0]   rsp_victim_page,
   output logic                          rsp_bypassed,
   output logic [FAULT_WIDTH-1:0]        rsp_fault_count,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [QUOTA_WIDTH-1:0]        csr_write_data
);

   plrud_cmd_type cmd;

   plrud_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   plrud_datapath #(
      .TENANT_COUNT     (TENANT_COUNT),
      .SLOTS_PER_TENANT (SLOTS_PER_TENANT),
      .PAGE_WIDTH       (PAGE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_tenant       (req_tenant),
      .req_page_number  (req_page_number),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_slot_number  (rsp_slot_number),
      .rsp_evicted      (rsp_evicted),
      .rsp_victim_page  (rsp_victim_page),
      .rsp_bypassed     (rsp_bypassed),
      .rsp_fault_count  (rsp_fault_count)
   );

endmodule

>>> bench/partitioned_lru_directory_checker.sv
// Checker for the partitioned LRU directory: watches the request, result and
// quota write ports, predicts each lookup and compares it with the block's result.
// Depends on plrud_pkg for the port widths and the quota register indexes.
module partitioned_lru_directory_checker
   import plrud_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [TENANT_FIELD_WIDTH-1:0] req_tenant,
   input  logic [PAGE_FIELD_WIDTH-1:0]   req_page_number,
   input  logic                          rsp_valid,
   input  logic                          rsp_hit,
   input  logic [SLOT_FIELD_WIDTH-1:0]   rsp_slot_number,
   input  logic                          rsp_evicted,
   input  logic [PAGE_FIELD_WIDTH-1:0]   rsp_victim_page,
   input  logic                          rsp_bypassed,
   input  logic [FAULT_WIDTH-1:0]        rsp_fault_count,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [QUOTA_WIDTH-1:0]        csr_write_data,
   output int                            mismatch_count,
   output int                            outstanding,
   output int                            checked_count,
   output int                            hit_count,
   output int                            eviction_count,
   output int                            bypass_count
);

   localparam int TENANTS = TENANT_COUNT_DEFAULT;
   localparam int SLOTS   = SLOTS_PER_TENANT_DEFAULT;

   typedef struct packed {
      logic                        hit;
      logic [SLOT_FIELD_WIDTH-1:0] slot_number;
      logic                        evicted;
      logic [PAGE_FIELD_WIDTH-1:0] victim_page;
      logic                        bypassed;
      logic [FAULT_WIDTH-1:0]      fault_count;
   } lookup_result_type;

   logic [QUOTA_WIDTH-1:0]      quota_shadow [TENANTS];
   logic [PAGE_FIELD_WIDTH-1:0] slot_page [TENANTS][SLOTS];
   logic [3:0]                  slot_age [TENANTS][SLOTS];
   int                          fill_count [TENANTS];
   logic [FAULT_WIDTH-1:0]      fault_total [TENANTS];
   lookup_result_type           pending_lookups [$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      checked_count  = 0;
      hit_count      = 0;
      eviction_count = 0;
      bypass_count   = 0;
   end

   function automatic void age_slots(input int tenant, input int limit);
      int i;
      for (i = 0; i < fill_count[tenant]; i++) begin
         if (int'(slot_age[tenant][i]) < limit) begin
            slot_age[tenant][i] = slot_age[tenant][i] + 4'd1;
         end
      end
   endfunction

   function automatic lookup_result_type predict_lookup(input int tenant,
                                                        input logic [PAGE_FIELD_WIDTH-1:0] page);
      lookup_result_type r;
      int                limit;
      int                slot;
      int                i;
      logic              found;
      r = '0;
      found = 1'b0;
      slot = 0;
      limit = (int'(quota_shadow[tenant]) > SLOTS) ? SLOTS : int'(quota_shadow[tenant]);
      if (limit != 0) begin
         for (i = 0; i < fill_count[tenant]; i++) begin
            if (!found && slot_page[tenant][i] == page) begin
               found = 1'b1;
               slot = i;
            end
         end
      end
      if (!found && fault_total[tenant] != '1) begin
         fault_total[tenant] = fault_total[tenant] + FAULT_WIDTH'(1);
      end
      r.fault_count = fault_total[tenant];
      if (limit == 0) begin
         r.bypassed = 1'b1;
      end else begin
         if (found) begin
            age_slots(tenant, int'(slot_age[tenant][slot]));
            slot_age[tenant][slot] = '0;
         end else if (fill_count[tenant] >= limit) begin
            for (i = 1; i < fill_count[tenant]; i++) begin
               if (slot_age[tenant][i] > slot_age[tenant][slot]) begin
                  slot = i;
               end
            end
            r.evicted = 1'b1;
            r.victim_page = slot_page[tenant][slot];
            age_slots(tenant, int'(slot_age[tenant][slot]));
            slot_age[tenant][slot] = '0;
            slot_page[tenant][slot] = page;
         end else begin
            slot = fill_count[tenant];
            age_slots(tenant, SLOTS);
            slot_age[tenant][slot] = '0;
            slot_page[tenant][slot] = page;
            fill_count[tenant] = fill_count[tenant] + 1;
         end
         r.hit = found;
         r.slot_number = SLOT_FIELD_WIDTH'(slot + 1);
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      lookup_result_type seen;
      lookup_result_type want;
      int                t;
      if (reset) begin
         for (t = 0; t < TENANTS; t++) begin
            quota_shadow[t] = QUOTA_RESET;
            fill_count[t] = 0;
            fault_total[t] = '0;
         end
         pending_lookups.delete();
         outstanding <= 0;
      end else begin
         if (csr_write_enable && csr_index <= REG_QUOTA_TENANT3) begin
            quota_shadow[csr_index] = csr_write_data;
         end
         if (rsp_valid) begin
            seen.hit = rsp_hit;
            seen.slot_number = rsp_slot_number;
            seen.evicted = rsp_evicted;
            seen.victim_page = rsp_victim_page;
            seen.bypassed = rsp_bypassed;
            seen.fault_count = rsp_fault_count;
            if (pending_lookups.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) begin
                  $display("ERROR: result with no request outstanding: hit %0b slot %0d",
                           seen.hit, seen.slot_number);
               end
            end else begin
               want = pending_lookups.pop_front();
               checked_count = checked_count + 1;
               if (seen !== want) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10) begin
                     $display("ERROR: result %0d expected hit %0b slot %0d evicted %0b",
                              checked_count, want.hit, want.slot_number, want.evicted);
                     $display("       victim %h bypassed %0b faults %0d",
                              want.victim_page, want.bypassed, want.fault_count);
                     $display("       got hit %0b slot %0d evicted %0b",
                              seen.hit, seen.slot_number, seen.evicted);
                     $display("       victim %h bypassed %0b faults %0d",
                              seen.victim_page, seen.bypassed, seen.fault_count);
                  end
               end
            end
         end
         if (start && !busy) begin
            want = predict_lookup(int'(req_tenant), req_page_number);
            pending_lookups = {pending_lookups, want};
            hit_count = hit_count + int'(want.hit);
            eviction_count = eviction_count + int'(want.evicted);
            bypass_count = bypass_count + int'(want.bypassed);
         end
         outstanding <= pending_lookups.size();
      end
   end

endmodule

>>> bench/partitioned_lru_directory_tb.sv
// Testbench top for the partitioned LRU directory: drives directed and random
// requests and quota settings, and reports the verdict.
// Depends on plrud_pkg, partitioned_lru_directory and partitioned_lru_directory_checker.
module partitioned_lru_directory_tb;
   import plrud_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 195;
   localparam int POOL_DEPTH      = 24;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          start            = 1'b0;
   logic                          busy;
   logic [TENANT_FIELD_WIDTH-1:0] req_tenant       = '0;
   logic [PAGE_FIELD_WIDTH-1:0]   req_page_number  = '0;
   logic                          rsp_valid;
   logic                          rsp_hit;
   logic [SLOT_FIELD_WIDTH-1:0]   rsp_slot_number;
   logic                          rsp_evicted;
   logic [PAGE_FIELD_WIDTH-1:0]   rsp_victim_page;
   logic                          rsp_bypassed;
   logic [FAULT_WIDTH-1:0]        rsp_fault_count;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index        = '0;
   logic [QUOTA_WIDTH-1:0]        csr_write_data   = '0;

   int mismatch_count;
   int outstanding;
   int checked_count;
   int hit_count;
   int eviction_count;
   int bypass_count;

   int cycle_count   = 0;
   int idle_percent  = 0;
   int sent_count    = 0;
   int setting_count = 0;

   logic [QUOTA_WIDTH-1:0]      quota_plan [QUOTA_REGS];
   logic [CSR_INDEX_WIDTH-1:0]  quota_index [QUOTA_REGS] =
      '{REG_QUOTA_TENANT0, REG_QUOTA_TENANT1, REG_QUOTA_TENANT2, REG_QUOTA_TENANT3};
   logic [PAGE_FIELD_WIDTH-1:0] page_pool [QUOTA_REGS][POOL_DEPTH];

   partitioned_lru_directory i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_tenant       (req_tenant),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_slot_number  (rsp_slot_number),
      .rsp_evicted      (rsp_evicted),
      .rsp_victim_page  (rsp_victim_page),
      .rsp_bypassed     (rsp_bypassed),
      .rsp_fault_count  (rsp_fault_count),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   partitioned_lru_directory_checker i_checker (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("partitioned_lru_directory_tb NOT OK");
         $finish;
      end
   end

   task automatic send_request(input logic [TENANT_FIELD_WIDTH-1:0] tenant,
                               input logic [PAGE_FIELD_WIDTH-1:0] page);
      logic ready;
      while ($urandom_range(0, 99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_tenant <= tenant;
      req_page_number <= page;
      ready = 1'b0;
      while (!ready) begin
         @(negedge clock);
         ready = !busy;
         @(posedge clock);
      end
      sent_count++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic program_quotas();
      int r;
      for (r = 0; r < QUOTA_REGS; r++) begin
         csr_write_enable <= 1'b1;
         csr_index <= quota_index[r];
         csr_write_data <= quota_plan[r];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      setting_count++;
   endtask

   initial begin
      int phase;
      int n;
      int t;
      int k;
      int span;
      logic [TENANT_FIELD_WIDTH-1:0] tenant;
      logic [PAGE_FIELD_WIDTH-1:0]   page;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Default quotas: fills, a hit, and tenants kept apart.
      send_request(2'd0, 16'h0000);
      send_request(2'd0, 16'hFFFF);
      send_request(2'd0, 16'h0000);
      send_request(2'd1, 16'h0000);
      send_request(2'd2, 16'hAAAA);
      send_request(2'd3, 16'h5555);
      send_request(2'd3, 16'h5555);

      // Full tenant evicts, zero quota bypasses, oversized quotas saturate.
      wait_idle();
      quota_plan = '{5'd2, 5'd0, 5'd31, 5'd17};
      program_quotas();
      send_request(2'd0, 16'h1234);
      send_request(2'd1, 16'h0000);
      send_request(2'd2, 16'hAAAA);
      send_request(2'd3, 16'hFFFF);

      // Quotas below the fill level keep every filled slot in play.
      wait_idle();
      quota_plan = '{5'd1, 5'd16, 5'd0, 5'd1};
      program_quotas();
      send_request(2'd0, 16'h0000);
      send_request(2'd0, 16'hBEEF);
      send_request(2'd1, 16'h0000);
      send_request(2'd2, 16'h5555);
      send_request(2'd3, 16'h0001);

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         for (t = 0; t < QUOTA_REGS; t++) begin
            case ((phase + t) % 6)
               0: quota_plan[t] = 5'd0;
               1: quota_plan[t] = 5'd1;
               2: quota_plan[t] = 5'd16;
               3: quota_plan[t] = 5'd31;
               4: quota_plan[t] = QUOTA_WIDTH'($urandom_range(2, 15));
               default: quota_plan[t] = QUOTA_WIDTH'($urandom_range(0, 31));
            endcase
            for (k = 0; k < POOL_DEPTH; k++) begin
               page_pool[t][k] = PAGE_FIELD_WIDTH'($urandom);
            end
         end
         program_quotas();
         case (phase % 4)
            1: idle_percent = 73;
            3: idle_percent = 15;
            default: idle_percent = 0;
         endcase
         span = $urandom_range(3, POOL_DEPTH - 1);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            tenant = TENANT_FIELD_WIDTH'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 80) begin
               page = page_pool[tenant][$urandom_range(0, span)];
            end else begin
               page = PAGE_FIELD_WIDTH'($urandom);
            end
            send_request(tenant, page);
         end
      end

      wait_idle();
      $display("Sent %0d requests under %0d quota settings; %0d results checked.",
               sent_count, setting_count, checked_count);
      $display("Hits %0d, evictions %0d, bypassed %0d, mismatches %0d.",
               hit_count, eviction_count, bypass_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("partitioned_lru_directory_tb OK");
      end else begin
         $display("partitioned_lru_directory_tb NOT OK");
      end
      $finish;
   end

endmodule
